[rtl/core/assert_macros.svh]
// assertion helpers used by the checker file
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define JSSF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jssf checker: implication failed");

// next-cycle implication, disabled while in reset
`define JSSF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jssf checker: next-cycle implication failed");

`endif

[rtl/core/jssf_pkg.sv]
// ----------------------------------------------------------------------------
// jssf_pkg
// Types, codes and defaults shared by the JSON symbol status filter.
// ----------------------------------------------------------------------------
package jssf_pkg;

  // default bound on the skip nesting counter
  localparam int unsigned JSSF_MAX_SKIP_DEPTH = 255;

  // token kinds from the tokenizer
  typedef logic [3:0] token_kind_t;
  localparam token_kind_t TK_OBJ_START = 4'd0;
  localparam token_kind_t TK_OBJ_END   = 4'd1;
  localparam token_kind_t TK_ARR_START = 4'd2;
  localparam token_kind_t TK_ARR_END   = 4'd3;
  localparam token_kind_t TK_STRING    = 4'd4;
  localparam token_kind_t TK_COLON     = 4'd5;
  localparam token_kind_t TK_COMMA     = 4'd6;
  localparam token_kind_t TK_SCALAR    = 4'd7;

  // pre-classified string values
  typedef logic [2:0] string_class_t;
  localparam string_class_t SC_OTHER    = 3'd0;
  localparam string_class_t SC_SYMBOLS  = 3'd1;
  localparam string_class_t SC_STATUS   = 3'd2;
  localparam string_class_t SC_PERMSETS = 3'd3;
  localparam string_class_t SC_TRADING  = 3'd4;
  localparam string_class_t SC_SPOT     = 3'd5;

  // class of the key whose value comes next
  typedef logic [1:0] key_class_t;
  localparam key_class_t KEY_OTHER    = 2'd0;
  localparam key_class_t KEY_SYMBOLS  = 2'd1;
  localparam key_class_t KEY_STATUS   = 2'd2;
  localparam key_class_t KEY_PERMSETS = 2'd3;

  // request operation
  localparam logic OP_TOKEN   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result outcome
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_BUSY  = 2'd0;
  localparam outcome_t OUT_DONE  = 2'd1;
  localparam outcome_t OUT_ERROR = 2'd2;

  // grammar states
  typedef enum logic [17:0] {
    ST_ROOT_START  = 18'h00001,
    ST_ROOT_KEY    = 18'h00002,
    ST_ROOT_COLON  = 18'h00004,
    ST_ROOT_VALUE  = 18'h00008,
    ST_ROOT_SEP    = 18'h00010,
    ST_ROOT_SKIP   = 18'h00020,
    ST_SYM0_START  = 18'h00040,
    ST_SYM_KEY     = 18'h00080,
    ST_SYM_COLON   = 18'h00100,
    ST_SYM_VALUE   = 18'h00200,
    ST_SYM_SEP     = 18'h00400,
    ST_SYM_SKIP    = 18'h00800,
    ST_PSET_START  = 18'h01000,
    ST_PERM_STR    = 18'h02000,
    ST_PERM_SEP    = 18'h04000,
    ST_PSETS_SEP   = 18'h08000,
    ST_DONE        = 18'h10000,
    ST_ERROR       = 18'h20000
  } gstate_t;

  // one request as held in the input register
  typedef struct packed {
    logic          op;
    token_kind_t   token_kind;
    string_class_t string_class;
  } jssf_item_t;

  // one result
  typedef struct packed {
    outcome_t outcome;
    logic     trading_status;
    logic     spot_allowed;
  } jssf_result_t;

endpackage

[rtl/core/jssf_if.sv]
// ----------------------------------------------------------------------------
// jssf_in_if / jssf_out_if
// Valid/ready channels for token requests and filter results.
// ----------------------------------------------------------------------------
interface jssf_in_if;
  import jssf_pkg::*;

  logic          valid;
  logic          ready;
  logic          op;
  token_kind_t   token_kind;
  string_class_t string_class;

  modport source (output valid, output op, output token_kind, output string_class,
                  input ready);
  modport sink   (input valid, input op, input token_kind, input string_class,
                  output ready);
endinterface

interface jssf_out_if;
  import jssf_pkg::*;

  logic     valid;
  logic     ready;
  outcome_t outcome;
  logic     trading_status;
  logic     spot_allowed;

  modport source (output valid, output outcome, output trading_status,
                  output spot_allowed, input ready);
  modport sink   (input valid, input outcome, input trading_status,
                  input spot_allowed, output ready);
endinterface

[rtl/core/jssf_in_stage.sv]
// ----------------------------------------------------------------------------
// jssf_in_stage
// Input register: captures one request a cycle while the next stage moves on.
// ----------------------------------------------------------------------------
module jssf_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  jssf_in_if.sink             in_ch,
  input  logic                take,
  output logic                s1_valid,
  output jssf_pkg::jssf_item_t s1_item
);
  import jssf_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  jssf_item_t item_r;
  logic       load;

  // free when empty or when the held request moves on this cycle
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{op: in_ch.op, token_kind: in_ch.token_kind,
                  string_class: in_ch.string_class};
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule

[rtl/core/jssf_grammar.sv]
// ----------------------------------------------------------------------------
// jssf_grammar
// Grammar state machine, skip counter and sticky flags; one token a step.
// ----------------------------------------------------------------------------
module jssf_grammar #(
  parameter int unsigned MAX_SKIP_DEPTH = jssf_pkg::JSSF_MAX_SKIP_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  jssf_pkg::jssf_item_t   item,
  output jssf_pkg::jssf_result_t result
);
  import jssf_pkg::*;

  localparam int unsigned SKIP_W = $clog2(MAX_SKIP_DEPTH + 1);
  localparam logic [SKIP_W-1:0] SKIP_MAX = SKIP_W'(MAX_SKIP_DEPTH);
  localparam logic [SKIP_W-1:0] SKIP_ONE = SKIP_W'(1);

  gstate_t           st_r,      st_nxt;
  key_class_t        key_r,     key_nxt;
  logic [SKIP_W-1:0] skip_r,    skip_nxt;
  logic              status_r,  status_nxt;
  logic              trading_r, trading_nxt;
  logic              spot_r,    spot_nxt;

  token_kind_t       tk;
  string_class_t     sc;
  logic              opener;
  logic              closer;
  logic [SKIP_W-1:0] first_cnt;
  logic              first_done;
  logic [SKIP_W-1:0] cont_cnt;
  logic              cont_ovf;
  logic              cont_done;
  gstate_t           close_st;

  assign tk = item.token_kind;
  assign sc = item.string_class;

  // skip counter: first token of a skipped value, and tokens inside it
  assign opener     = (tk == TK_OBJ_START) || (tk == TK_ARR_START);
  assign closer     = (tk == TK_OBJ_END) || (tk == TK_ARR_END);
  assign first_cnt  = opener ? SKIP_ONE : '0;
  assign first_done = !opener;
  assign cont_ovf   = opener && (skip_r >= SKIP_MAX);

  always_comb begin
    cont_cnt = skip_r;
    if (opener && !cont_ovf) begin
      cont_cnt = skip_r + SKIP_ONE;
    end else if (closer && (skip_r != '0)) begin
      cont_cnt = skip_r - SKIP_ONE;
    end
  end

  assign cont_done = (cont_cnt == '0);

  // symbol object end is only good once a status was seen
  assign close_st = status_r ? ST_DONE : ST_ERROR;

  // next state
  always_comb begin
    st_nxt      = st_r;
    key_nxt     = key_r;
    skip_nxt    = skip_r;
    status_nxt  = status_r;
    trading_nxt = trading_r;
    spot_nxt    = spot_r;
    if (item.op == OP_RESTART) begin
      st_nxt      = ST_ROOT_START;
      key_nxt     = KEY_OTHER;
      skip_nxt    = '0;
      status_nxt  = 1'b0;
      trading_nxt = 1'b0;
      spot_nxt    = 1'b0;
    end else if ((st_r != ST_DONE) && (st_r != ST_ERROR)) begin
      if (tk > TK_SCALAR) begin
        st_nxt = ST_ERROR;
      end else begin
        unique case (st_r)
          ST_ROOT_START: begin
            st_nxt = (tk == TK_OBJ_START) ? ST_ROOT_KEY : ST_ERROR;
          end
          ST_ROOT_KEY: begin
            if (tk != TK_STRING) begin
              st_nxt = ST_ERROR;
            end else begin
              key_nxt = (sc == SC_SYMBOLS) ? KEY_SYMBOLS : KEY_OTHER;
              st_nxt  = ST_ROOT_COLON;
            end
          end
          ST_ROOT_COLON: begin
            st_nxt = (tk == TK_COLON) ? ST_ROOT_VALUE : ST_ERROR;
          end
          ST_ROOT_VALUE: begin
            if (key_r == KEY_SYMBOLS) begin
              st_nxt = (tk == TK_ARR_START) ? ST_SYM0_START : ST_ERROR;
            end else begin
              skip_nxt = first_cnt;
              st_nxt   = first_done ? ST_ROOT_SEP : ST_ROOT_SKIP;
            end
          end
          ST_ROOT_SEP: begin
            st_nxt = (tk == TK_COMMA) ? ST_ROOT_KEY : ST_ERROR;
          end
          ST_ROOT_SKIP: begin
            skip_nxt = cont_cnt;
            st_nxt   = cont_ovf ? ST_ERROR : (cont_done ? ST_ROOT_SEP : ST_ROOT_SKIP);
          end
          ST_SYM0_START: begin
            st_nxt = (tk == TK_OBJ_START) ? ST_SYM_KEY : ST_ERROR;
          end
          ST_SYM_KEY: begin
            if (tk == TK_OBJ_END) begin
              st_nxt = close_st;
            end else if (tk != TK_STRING) begin
              st_nxt = ST_ERROR;
            end else begin
              key_nxt = (sc == SC_STATUS)   ? KEY_STATUS :
                        (sc == SC_PERMSETS) ? KEY_PERMSETS : KEY_OTHER;
              st_nxt  = ST_SYM_COLON;
            end
          end
          ST_SYM_COLON: begin
            st_nxt = (tk == TK_COLON) ? ST_SYM_VALUE : ST_ERROR;
          end
          ST_SYM_VALUE: begin
            if (key_r == KEY_STATUS) begin
              if (tk != TK_STRING) begin
                st_nxt = ST_ERROR;
              end else begin
                trading_nxt = (sc == SC_TRADING);
                status_nxt  = 1'b1;
                st_nxt      = ST_SYM_SEP;
              end
            end else if (key_r == KEY_PERMSETS) begin
              st_nxt = (tk == TK_ARR_START) ? ST_PSET_START : ST_ERROR;
            end else begin
              skip_nxt = first_cnt;
              st_nxt   = first_done ? ST_SYM_SEP : ST_SYM_SKIP;
            end
          end
          ST_SYM_SEP: begin
            if (tk == TK_COMMA) begin
              st_nxt = ST_SYM_KEY;
            end else if (tk == TK_OBJ_END) begin
              st_nxt = close_st;
            end else begin
              st_nxt = ST_ERROR;
            end
          end
          ST_SYM_SKIP: begin
            skip_nxt = cont_cnt;
            st_nxt   = cont_ovf ? ST_ERROR : (cont_done ? ST_SYM_SEP : ST_SYM_SKIP);
          end
          ST_PSET_START: begin
            if (tk == TK_ARR_END) begin
              st_nxt = ST_SYM_SEP;
            end else begin
              st_nxt = (tk == TK_ARR_START) ? ST_PERM_STR : ST_ERROR;
            end
          end
          ST_PERM_STR: begin
            if (tk == TK_ARR_END) begin
              st_nxt = ST_PSETS_SEP;
            end else if (tk != TK_STRING) begin
              st_nxt = ST_ERROR;
            end else begin
              if (sc == SC_SPOT) begin
                spot_nxt = 1'b1;
              end
              st_nxt = ST_PERM_SEP;
            end
          end
          ST_PERM_SEP: begin
            if (tk == TK_COMMA) begin
              st_nxt = ST_PERM_STR;
            end else if (tk == TK_ARR_END) begin
              st_nxt = ST_PSETS_SEP;
            end else begin
              st_nxt = ST_ERROR;
            end
          end
          ST_PSETS_SEP: begin
            if (tk == TK_COMMA) begin
              st_nxt = ST_PSET_START;
            end else if (tk == TK_ARR_END) begin
              st_nxt = ST_SYM_SEP;
            end else begin
              st_nxt = ST_ERROR;
            end
          end
          ST_DONE, ST_ERROR: begin
            st_nxt = st_r;
          end
          default: begin
            st_nxt = ST_ERROR;
          end
        endcase
      end
    end
  end

  // state registers, advanced once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_ROOT_START;
      key_r     <= KEY_OTHER;
      skip_r    <= '0;
      status_r  <= 1'b0;
      trading_r <= 1'b0;
      spot_r    <= 1'b0;
    end else if (fire) begin
      st_r      <= st_nxt;
      key_r     <= key_nxt;
      skip_r    <= skip_nxt;
      status_r  <= status_nxt;
      trading_r <= trading_nxt;
      spot_r    <= spot_nxt;
    end
  end

  // result reflects the state after this token
  always_comb begin
    result.outcome = (st_nxt == ST_DONE)  ? OUT_DONE  :
                     (st_nxt == ST_ERROR) ? OUT_ERROR : OUT_BUSY;
    result.trading_status = trading_nxt;
    result.spot_allowed   = spot_nxt;
  end
endmodule

[rtl/core/jssf_out_stage.sv]
// ----------------------------------------------------------------------------
// jssf_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module jssf_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  jssf_pkg::jssf_result_t result,
  output logic                   take,
  output logic                   fire,
  jssf_out_if.source             out_ch
);
  import jssf_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  jssf_result_t result_r;

  // register is free when empty or drained this cycle
  assign take = !valid_r || out_ch.ready;
  assign fire = s1_valid && take;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.outcome        = result_r.outcome;
  assign out_ch.trading_status = result_r.trading_status;
  assign out_ch.spot_allowed   = result_r.spot_allowed;
endmodule

[rtl/core/json_symbol_status_filter.sv]
// ----------------------------------------------------------------------------
// json_symbol_status_filter
// Token-level filter that finds the first symbol's status and spot permission.
// ----------------------------------------------------------------------------
// Takes one tokenizer request per clock and returns one result per request,
// in order. A request passes an input register, one grammar step and a result
// register, so its result is shown once the result register has taken it;
// a new request is accepted every cycle while the sink keeps up,
// and a result left waiting lets one more request into the input register
// before the input stalls. The rate is set by the single-step grammar update
// between those two registers. A result carries the outcome (in progress,
// done, parse error) and the sticky trading and spot flags as they stand
// after that request. Done and error hold until a restart request, which
// clears everything and answers in progress with both flags low. Values that
// are skipped may nest up to MAX_SKIP_DEPTH deep; one more level is an error.
module json_symbol_status_filter #(
  parameter int unsigned MAX_SKIP_DEPTH = jssf_pkg::JSSF_MAX_SKIP_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  jssf_in_if.sink    in_ch,
  jssf_out_if.source out_ch
);
  import jssf_pkg::*;

  logic         take;
  logic         fire;
  logic         s1_valid;
  jssf_item_t   s1_item;
  jssf_result_t result;

  // input register
  jssf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // grammar step
  jssf_grammar #(
    .MAX_SKIP_DEPTH (MAX_SKIP_DEPTH)
  ) u_grammar (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item),
    .result (result)
  );

  // result register
  jssf_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .result   (result),
    .take     (take),
    .fire     (fire),
    .out_ch   (out_ch)
  );
endmodule

[rtl/core/jssf_checker.sv]
// ----------------------------------------------------------------------------
// jssf_checker
// Port-level checks for the JSON symbol status filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jssf_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_op,
  input logic                     out_valid,
  input logic                     out_ready,
  input jssf_pkg::outcome_t       out_outcome,
  input logic                     out_trading_status,
  input logic                     out_spot_allowed
);
  import jssf_pkg::*;

  logic [3:0] out_payload;
  logic       restart_acc;
  logic       out_free;
  logic       out_clear;

  // result fields seen together, and the restart answer
  assign out_payload = {out_outcome, out_trading_status, out_spot_allowed};
  assign restart_acc = in_valid && in_ready && (in_op == OP_RESTART);
  assign out_free    = !out_valid || out_ready;
  assign out_clear   = out_valid && (out_outcome == OUT_BUSY) && !out_trading_status &&
                       !out_spot_allowed;

  // a waiting result stays offered
  `JSSF_ASSERT_NXT(a_out_valid_hold, out_valid && !out_ready, out_valid)

  // a waiting result keeps its value
  `JSSF_ASSERT_NXT(a_out_data_hold, out_valid && !out_ready, $stable(out_payload))

  // with no result pending the block always takes a request
  `JSSF_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

  // a restart request that moves on unblocked answers in progress, flags low
  `JSSF_ASSERT_NXT(a_restart_clears, restart_acc ##1 out_free, out_clear)
endmodule

bind json_symbol_status_filter jssf_checker u_jssf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_op              (in_ch.op),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_outcome        (out_ch.outcome),
  .out_trading_status (out_ch.trading_status),
  .out_spot_allowed   (out_ch.spot_allowed)
);

[verif/json_symbol_status_filter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_symbol_status_filter_tb
// Drives token requests through the status filter and checks every result
// against a cycle-free model of the grammar, skip counter and sticky flags.
// Starts with hand-built messages, then skips at the depth bound and one past
// it, then a run of random messages with corruption and noise.
// ----------------------------------------------------------------------------
module json_symbol_status_filter_tb;
  import jssf_pkg::*;

  localparam int unsigned SKIP_LIMIT   = JSSF_MAX_SKIP_DEPTH;
  localparam int          TOTAL_ITEMS  = 1750;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          MAX_REPORTS  = 10;

  // token kinds and string classes that carry no name in the package
  localparam token_kind_t   TK_SCAN_ERROR = 4'd8;
  localparam token_kind_t   TK_TOP_CODE   = 4'd15;
  localparam string_class_t SC_TOP_CODE   = 3'd7;

  // model of the filter plus the store of results still to come
  class status_filter_checker;
    gstate_t      gstate;
    key_class_t   next_key;
    int unsigned  nesting;
    int unsigned  depth_limit;
    bit           status_seen;
    bit           trading;
    bit           spot;
    jssf_result_t expected_results[$];
    int           mismatches;
    int           requests;
    int           live_requests;
    int           restarts;
    int           checked;
    int           done_count;
    int           error_count;

    function new(int unsigned limit);
      depth_limit = limit;
      clear_state();
    endfunction

    function void clear_state();
      gstate      = ST_ROOT_START;
      next_key    = KEY_OTHER;
      nesting     = 0;
      status_seen = 1'b0;
      trading     = 1'b0;
      spot        = 1'b0;
    endfunction

    // one token of a value being skipped; first marks the token that opens it
    function gstate_t skip_value(token_kind_t tk, bit first, gstate_t in_value,
                                 gstate_t past_value);
      bit opener;
      bit closer;
      opener = (tk == TK_OBJ_START) || (tk == TK_ARR_START);
      closer = (tk == TK_OBJ_END) || (tk == TK_ARR_END);
      if (first) begin
        nesting = opener ? 1 : 0;
        return opener ? in_value : past_value;
      end
      if (opener) begin
        if (nesting >= depth_limit) return ST_ERROR;
        nesting++;
      end else if (closer && nesting > 0) begin
        nesting--;
      end
      return (nesting == 0) ? past_value : in_value;
    endfunction

    function gstate_t close_symbol();
      return status_seen ? ST_DONE : ST_ERROR;
    endfunction

    function void advance_grammar(token_kind_t tk, string_class_t sc);
      if (tk > TK_SCALAR) begin
        gstate = ST_ERROR;
        return;
      end
      case (gstate)
        ST_ROOT_START: gstate = (tk == TK_OBJ_START) ? ST_ROOT_KEY : ST_ERROR;
        ST_ROOT_KEY: begin
          if (tk != TK_STRING) begin
            gstate = ST_ERROR;
          end else begin
            next_key = (sc == SC_SYMBOLS) ? KEY_SYMBOLS : KEY_OTHER;
            gstate   = ST_ROOT_COLON;
          end
        end
        ST_ROOT_COLON: gstate = (tk == TK_COLON) ? ST_ROOT_VALUE : ST_ERROR;
        ST_ROOT_VALUE: begin
          if (next_key == KEY_SYMBOLS) begin
            gstate = (tk == TK_ARR_START) ? ST_SYM0_START : ST_ERROR;
          end else begin
            gstate = skip_value(tk, 1'b1, ST_ROOT_SKIP, ST_ROOT_SEP);
          end
        end
        ST_ROOT_SEP:   gstate = (tk == TK_COMMA) ? ST_ROOT_KEY : ST_ERROR;
        ST_ROOT_SKIP:  gstate = skip_value(tk, 1'b0, ST_ROOT_SKIP, ST_ROOT_SEP);
        ST_SYM0_START: gstate = (tk == TK_OBJ_START) ? ST_SYM_KEY : ST_ERROR;
        ST_SYM_KEY: begin
          if (tk == TK_OBJ_END) begin
            gstate = close_symbol();
          end else if (tk != TK_STRING) begin
            gstate = ST_ERROR;
          end else begin
            if (sc == SC_STATUS) next_key = KEY_STATUS;
            else if (sc == SC_PERMSETS) next_key = KEY_PERMSETS;
            else next_key = KEY_OTHER;
            gstate = ST_SYM_COLON;
          end
        end
        ST_SYM_COLON: gstate = (tk == TK_COLON) ? ST_SYM_VALUE : ST_ERROR;
        ST_SYM_VALUE: begin
          if (next_key == KEY_STATUS) begin
            if (tk != TK_STRING) begin
              gstate = ST_ERROR;
            end else begin
              trading     = (sc == SC_TRADING);
              status_seen = 1'b1;
              gstate      = ST_SYM_SEP;
            end
          end else if (next_key == KEY_PERMSETS) begin
            gstate = (tk == TK_ARR_START) ? ST_PSET_START : ST_ERROR;
          end else begin
            gstate = skip_value(tk, 1'b1, ST_SYM_SKIP, ST_SYM_SEP);
          end
        end
        ST_SYM_SEP: begin
          if (tk == TK_COMMA) gstate = ST_SYM_KEY;
          else if (tk == TK_OBJ_END) gstate = close_symbol();
          else gstate = ST_ERROR;
        end
        ST_SYM_SKIP: gstate = skip_value(tk, 1'b0, ST_SYM_SKIP, ST_SYM_SEP);
        ST_PSET_START: begin
          if (tk == TK_ARR_END) gstate = ST_SYM_SEP;
          else if (tk == TK_ARR_START) gstate = ST_PERM_STR;
          else gstate = ST_ERROR;
        end
        ST_PERM_STR: begin
          if (tk == TK_ARR_END) begin
            gstate = ST_PSETS_SEP;
          end else if (tk != TK_STRING) begin
            gstate = ST_ERROR;
          end else begin
            if (sc == SC_SPOT) spot = 1'b1;
            gstate = ST_PERM_SEP;
          end
        end
        ST_PERM_SEP: begin
          if (tk == TK_COMMA) gstate = ST_PERM_STR;
          else if (tk == TK_ARR_END) gstate = ST_PSETS_SEP;
          else gstate = ST_ERROR;
        end
        ST_PSETS_SEP: begin
          if (tk == TK_COMMA) gstate = ST_PSET_START;
          else if (tk == TK_ARR_END) gstate = ST_SYM_SEP;
          else gstate = ST_ERROR;
        end
        ST_DONE: ;
        default: gstate = ST_ERROR;
      endcase
    endfunction

    // accepted request: step the model and queue the result it implies
    function void note_request(jssf_item_t req);
      jssf_result_t res;
      requests++;
      if (req.op == OP_RESTART) begin
        clear_state();
        restarts++;
        live_requests++;
      end else if (gstate != ST_DONE && gstate != ST_ERROR) begin
        live_requests++;
        advance_grammar(req.token_kind, req.string_class);
        if (gstate == ST_DONE) done_count++;
        else if (gstate == ST_ERROR) error_count++;
      end
      if (gstate == ST_DONE) res.outcome = OUT_DONE;
      else if (gstate == ST_ERROR) res.outcome = OUT_ERROR;
      else res.outcome = OUT_BUSY;
      res.trading_status = trading;
      res.spot_allowed   = spot;
      expected_results.push_back(res);
    endfunction

    // accepted result: compare against the oldest one outstanding
    function void check_result(jssf_result_t got);
      jssf_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: outcome %0d trading %0b spot %0b",
                   got.outcome, got.trading_status, got.spot_allowed);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.outcome !== want.outcome || got.trading_status !== want.trading_status ||
          got.spot_allowed !== want.spot_allowed) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b", checked,
                   want.outcome, want.trading_status, want.spot_allowed,
                   got.outcome, got.trading_status, got.spot_allowed);
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  jssf_in_if  in_ch ();
  jssf_out_if out_ch ();

  json_symbol_status_filter #(
    .MAX_SKIP_DEPTH (SKIP_LIMIT)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  status_filter_checker board;
  jssf_item_t           token_q[$];
  bit                   idling     = 1'b0;
  int unsigned          sink_stall = 0;
  int                   idle_cycles = 0;

  always #1 clk = ~clk;

  // mostly short stalls, now and then a long one
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // handshakes seen at the rising edge
  always @(posedge clk) begin
    jssf_item_t   req;
    jssf_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req.op           = in_ch.op;
        req.token_kind   = in_ch.token_kind;
        req.string_class = in_ch.string_class;
        board.note_request(req);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.outcome        = out_ch.outcome;
        got.trading_status = out_ch.trading_status;
        got.spot_allowed   = out_ch.spot_allowed;
        board.check_result(got);
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (sink_stall != 0) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= sink_stall - 1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= gap_length() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // token builders
  function automatic string_class_t any_class();
    return string_class_t'($urandom_range(0, 7));
  endfunction

  function automatic string_class_t class_except(string_class_t a, string_class_t b);
    string_class_t sc;
    do sc = any_class(); while (sc == a || sc == b);
    return sc;
  endfunction

  function automatic void add_token(logic op, token_kind_t tk, string_class_t sc);
    jssf_item_t t;
    t.op           = op;
    t.token_kind   = tk;
    t.string_class = sc;
    token_q.push_back(t);
  endfunction

  function automatic void add_mark(token_kind_t tk);
    add_token(OP_TOKEN, tk, any_class());
  endfunction

  function automatic void add_string(string_class_t sc);
    add_token(OP_TOKEN, TK_STRING, sc);
  endfunction

  function automatic void add_restart();
    add_token(OP_RESTART, token_kind_t'($urandom_range(0, 15)), any_class());
  endfunction

  // random well-formed value for the skip counter to walk over
  function automatic void add_skipped_value(int depth);
    int unsigned pick;
    int unsigned n;
    pick = (depth >= 3) ? $urandom_range(0, 1) : $urandom_range(0, 5);
    case (pick)
      0: add_string(any_class());
      1: add_mark(TK_SCALAR);
      2, 3: begin
        add_mark(TK_ARR_START);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i != 0) add_mark(TK_COMMA);
          add_skipped_value(depth + 1);
        end
        add_mark(TK_ARR_END);
      end
      default: begin
        add_mark(TK_OBJ_START);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          if (i != 0) add_mark(TK_COMMA);
          add_string(any_class());
          add_mark(TK_COLON);
          add_skipped_value(depth + 1);
        end
        add_mark(TK_OBJ_END);
      end
    endcase
  endfunction

  // nested permission arrays, some of them holding SPOT
  function automatic void add_permission_sets();
    int unsigned nsets;
    int unsigned nstr;
    add_mark(TK_ARR_START);
    nsets = $urandom_range(0, 3);
    for (int i = 0; i < nsets; i++) begin
      if (i != 0) add_mark(TK_COMMA);
      add_mark(TK_ARR_START);
      nstr = $urandom_range(0, 3);
      for (int j = 0; j < nstr; j++) begin
        if (j != 0) add_mark(TK_COMMA);
        add_string(($urandom_range(0, 2) == 0) ? SC_SPOT : any_class());
      end
      add_mark(TK_ARR_END);
    end
    add_mark(TK_ARR_END);
  endfunction

  // full message: other root keys, then the symbols array and its first object
  function automatic void build_symbol_message();
    int unsigned nfield;
    int unsigned pick;
    add_restart();
    add_mark(TK_OBJ_START);
    repeat ($urandom_range(0, 2)) begin
      add_string(class_except(SC_SYMBOLS, SC_SYMBOLS));
      add_mark(TK_COLON);
      add_skipped_value(0);
      add_mark(TK_COMMA);
    end
    add_string(SC_SYMBOLS);
    add_mark(TK_COLON);
    add_mark(TK_ARR_START);
    add_mark(TK_OBJ_START);
    nfield = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
    for (int f = 0; f < nfield; f++) begin
      if (f != 0) add_mark(TK_COMMA);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        add_string(SC_STATUS);
        add_mark(TK_COLON);
        add_string($urandom_range(0, 1) ? SC_TRADING : any_class());
      end else if (pick < 7) begin
        add_string(SC_PERMSETS);
        add_mark(TK_COLON);
        add_permission_sets();
      end else begin
        add_string(class_except(SC_STATUS, SC_PERMSETS));
        add_mark(TK_COLON);
        add_skipped_value(0);
      end
    end
    add_mark(TK_OBJ_END);
    // whatever follows the first symbol object is ignored
    repeat ($urandom_range(0, 2)) add_mark(token_kind_t'($urandom_range(0, 7)));
  endfunction

  // cut the message short or swap one token for a random one
  function automatic void corrupt_message();
    int unsigned at;
    at = $urandom_range(1, token_q.size() - 1);
    if ($urandom_range(0, 1)) begin
      while (token_q.size() > at) void'(token_q.pop_back());
    end else begin
      token_q[at].token_kind   = token_kind_t'($urandom_range(0, 15));
      token_q[at].string_class = any_class();
    end
  endfunction

  function automatic void build_noise();
    add_restart();
    if ($urandom_range(0, 1)) add_mark(TK_OBJ_START);
    repeat ($urandom_range(4, 16)) begin
      if ($urandom_range(0, 9) == 0) add_restart();
      else add_token(OP_TOKEN, token_kind_t'($urandom_range(0, 15)), any_class());
    end
  endfunction

  // skipped root value nested the given number of levels, then a good symbol
  function automatic void build_deep_skip(int unsigned levels);
    add_restart();
    add_mark(TK_OBJ_START);
    add_string(SC_OTHER);
    add_mark(TK_COLON);
    repeat (levels) add_mark($urandom_range(0, 1) ? TK_ARR_START : TK_OBJ_START);
    repeat (levels) add_mark($urandom_range(0, 1) ? TK_ARR_END : TK_OBJ_END);
    add_mark(TK_COMMA);
    add_string(SC_SYMBOLS);
    add_mark(TK_COLON);
    add_mark(TK_ARR_START);
    add_mark(TK_OBJ_START);
    add_string(SC_STATUS);
    add_mark(TK_COLON);
    add_string(SC_TRADING);
    add_mark(TK_OBJ_END);
  endfunction

  function automatic void build_directed();
    // trading with a spot permission, then a token past the end
    add_restart();
    add_mark(TK_OBJ_START);
    add_string(SC_SYMBOLS);
    add_mark(TK_COLON);
    add_mark(TK_ARR_START);
    add_mark(TK_OBJ_START);
    add_string(SC_STATUS);
    add_mark(TK_COLON);
    add_string(SC_TRADING);
    add_mark(TK_COMMA);
    add_string(SC_PERMSETS);
    add_mark(TK_COLON);
    add_mark(TK_ARR_START);
    add_mark(TK_ARR_START);
    add_string(SC_SPOT);
    add_mark(TK_ARR_END);
    add_mark(TK_ARR_END);
    add_mark(TK_OBJ_END);
    add_token(OP_TOKEN, TK_TOP_CODE, SC_TOP_CODE);
    // status key at root level is skipped, a closer is a whole value,
    // then an empty symbols array
    add_token(OP_RESTART, TK_TOP_CODE, SC_TOP_CODE);
    add_mark(TK_OBJ_START);
    add_string(SC_STATUS);
    add_mark(TK_COLON);
    add_mark(TK_OBJ_END);
    add_mark(TK_COMMA);
    add_string(SC_SYMBOLS);
    add_mark(TK_COLON);
    add_mark(TK_ARR_START);
    add_mark(TK_ARR_END);
    // symbol object closed without a status
    add_restart();
    add_mark(TK_OBJ_START);
    add_string(SC_SYMBOLS);
    add_mark(TK_COLON);
    add_mark(TK_ARR_START);
    add_mark(TK_OBJ_START);
    add_mark(TK_OBJ_END);
    // scan error straight after a restart
    add_token(OP_RESTART, TK_OBJ_START, SC_OTHER);
    add_mark(TK_SCAN_ERROR);
  endfunction

  // request driver, entered and left at a falling edge
  task automatic send_token(jssf_item_t req);
    int unsigned gap;
    gap = (idling && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= req.op;
    in_ch.token_kind   <= req.token_kind;
    in_ch.string_class <= req.string_class;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_tokens();
    foreach (token_q[i]) send_token(token_q[i]);
    token_q.delete();
  endtask

  // hold off new requests until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (board.expected_results.size() != 0);
  endtask

  initial begin
    int pick;
    board              = new(SKIP_LIMIT);
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_TOKEN;
    in_ch.token_kind   = TK_OBJ_START;
    in_ch.string_class = SC_OTHER;
    out_ch.ready       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // hand-built messages with no idling
    build_directed();
    send_tokens();
    wait_drained();

    // skip nesting right at the bound and one level past it
    idling = 1'b1;
    build_deep_skip(SKIP_LIMIT);
    build_deep_skip(SKIP_LIMIT + 1);
    send_tokens();
    wait_drained();

    // random messages, some corrupted, mixed with noise
    while (board.requests < TOTAL_ITEMS) begin
      idling = ($urandom_range(0, 4) != 0);
      pick   = $urandom_range(0, 9);
      if (pick < 7) begin
        build_symbol_message();
        if ($urandom_range(0, 3) == 0) corrupt_message();
      end else begin
        build_noise();
      end
      send_tokens();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("covered %0d token requests (%0d restarts, %0d ignored after the outcome)",
             board.requests, board.restarts, board.requests - board.live_requests);
    $display("%0d results checked, %0d messages done, %0d parse errors, %0d mismatches",
             board.checked, board.done_count, board.error_count, board.mismatches);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/jssf_pkg.sv
rtl/core/jssf_if.sv
rtl/core/jssf_in_stage.sv
rtl/core/jssf_grammar.sv
rtl/core/jssf_out_stage.sv
rtl/core/json_symbol_status_filter.sv
rtl/core/jssf_checker.sv
verif/json_symbol_status_filter_tb.sv
